// ----- rtl/buzzer_melody_player_unit_defines.svh -----
// Assertion macros for the buzzer melody player RTL
`ifndef BUZZER_MELODY_PLAYER_UNIT_DEFINES_SVH
`define BUZZER_MELODY_PLAYER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bmp_pkg.sv -----
// Types, constants and reload table for the buzzer melody player
`default_nettype none
package bmp_pkg;

  localparam int unsigned SCORE_DEPTH_DEF = 128;
  localparam int unsigned SCORE_W         = 16;

  localparam logic [7:0]  END_MARK   = 8'hFF;
  localparam logic [7:0]  NOTE_COUNT = 8'd37;

  localparam logic [15:0] CYCLES_PER_MS_RST = 16'd1000;
  localparam logic [9:0]  UNIT_MS_RST       = 10'd125;
  localparam logic [7:0]  GAP_MS_RST        = 8'd5;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  localparam logic [1:0] CFG_CYCLES_PER_MS = 2'd0;
  localparam logic [1:0] CFG_UNIT_MS       = 2'd1;
  localparam logic [1:0] CFG_GAP_MS        = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  function automatic logic [15:0] reload_value(input logic [5:0] note);
    logic [15:0] r;
    unique case (note)
      6'd1:  r = 16'd63628;
      6'd2:  r = 16'd63731;
      6'd3:  r = 16'd63835;
      6'd4:  r = 16'd63928;
      6'd5:  r = 16'd64021;
      6'd6:  r = 16'd64103;
      6'd7:  r = 16'd64185;
      6'd8:  r = 16'd64260;
      6'd9:  r = 16'd64331;
      6'd10: r = 16'd64400;
      6'd11: r = 16'd64463;
      6'd12: r = 16'd64528;
      6'd13: r = 16'd64580;
      6'd14: r = 16'd64633;
      6'd15: r = 16'd64684;
      6'd16: r = 16'd64732;
      6'd17: r = 16'd64777;
      6'd18: r = 16'd64820;
      6'd19: r = 16'd64860;
      6'd20: r = 16'd64898;
      6'd21: r = 16'd64934;
      6'd22: r = 16'd64968;
      6'd23: r = 16'd65000;
      6'd24: r = 16'd65030;
      6'd25: r = 16'd65058;
      6'd26: r = 16'd65085;
      6'd27: r = 16'd65110;
      6'd28: r = 16'd65134;
      6'd29: r = 16'd65157;
      6'd30: r = 16'd65178;
      6'd31: r = 16'd65198;
      6'd32: r = 16'd65217;
      6'd33: r = 16'd65235;
      6'd34: r = 16'd65252;
      6'd35: r = 16'd65268;
      6'd36: r = 16'd65283;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/buzzer_melody_player_unit.sv -----
// Buzzer melody player: score store, tone counter, note timing, output register
// Latency: a result appears in the output register the cycle after its request.
// One request per cycle unless out_ready stalls; RAM prefetches the next entry.
// Entry 0 is mirrored in a register so a start request needs no RAM read.
// Reset: pin high, idle, counters cleared, registers at defaults.
// The score store is not cleared by reset and has no clearing pass.
`default_nettype none
`include "buzzer_melody_player_unit_defines.svh"
module buzzer_melody_player_unit #(
  parameter int unsigned SCORE_DEPTH = bmp_pkg::SCORE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [6:0] in_entry_index,
  input  wire logic [7:0] in_note_code,
  input  wire logic [7:0] in_note_length,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_buzzer_level,
  output logic            out_playing,
  output logic            out_finished,
  output logic [6:0]      out_note_position
);
  import bmp_pkg::*;

  localparam int unsigned PW = $clog2(SCORE_DEPTH);

  // configuration
  logic [15:0] cpm_r;
  logic [9:0]  unit_r;
  logic [7:0]  gap_r;

  // player state
  phase_t      phase_r, phase_nxt;
  logic [15:0] tone_r, tone_nxt;
  logic        pin_r, pin_nxt;
  logic [5:0]  cur_r, cur_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [17:0] ms_r, ms_nxt;
  logic [15:0] cim_r, cim_nxt;
  logic        fin;

  // score store access
  logic [SCORE_W-1:0] e0_r;
  logic [SCORE_W-1:0] byp_data_r;
  logic               byp_vld_r;
  logic [SCORE_W-1:0] ram_rdata;
  logic               wr_en;
  logic [PW-1:0]      wr_addr;
  logic [PW+6:0]      wr_idx_ext;
  logic [PW:0]        pos_inc;
  logic [PW-1:0]      rd_addr;

  // output register
  logic       out_valid_r;
  logic       out_level_r, out_playing_r, out_fin_r;
  logic [6:0] out_pos_r;

  logic        in_acc;
  logic        is_tick, do_start, do_gap_end, do_load;
  logic        ct_done;
  logic [16:0] cim_inc;
  logic [17:0] ms_dec, ms_cnt, ms_load;
  logic [15:0] cim_cnt;
  logic [15:0] tone_inc, tone_rl;
  logic [SCORE_W-1:0] ld_entry;
  logic [7:0]  ld_code, ld_len;
  logic [PW:0] pos_ld;
  logic        ld_stop;
  logic [5:0]  ld_cur;
  logic [PW+6:0] pos_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // score RAM: write port from requests, read port always prefetches position + 1
  assign wr_en      = in_acc && (in_req_type == REQ_WRITE) && (32'(in_entry_index) < SCORE_DEPTH);
  assign wr_idx_ext = {{PW{1'b0}}, in_entry_index};
  assign wr_addr    = wr_idx_ext[PW-1:0];
  assign pos_inc    = {1'b0, pos_r} + {{PW{1'b0}}, 1'b1};
  assign rd_addr    = pos_inc[PW-1:0];

  bmp_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (SCORE_DEPTH)
  ) u_score_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_note_code, in_note_length}),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // same-edge write to the prefetched address is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
    end else begin
      byp_vld_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      byp_data_r <= {in_note_code, in_note_length};
    end
    if (wr_en && (wr_addr == '0)) begin
      e0_r <= {in_note_code, in_note_length};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpm_r  <= CYCLES_PER_MS_RST;
      unit_r <= UNIT_MS_RST;
      gap_r  <= GAP_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CYCLES_PER_MS: cpm_r  <= cfg_wdata;
        CFG_UNIT_MS:       unit_r <= cfg_wdata[9:0];
        CFG_GAP_MS:        gap_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign is_tick    = in_acc && (in_req_type == REQ_TICK);
  assign do_start   = in_acc && (in_req_type == REQ_START);
  assign do_gap_end = is_tick && (phase_r == PH_GAP) && ct_done;
  assign do_load    = do_start || do_gap_end;

  // millisecond timing of the current phase
  assign cim_inc = {1'b0, cim_r} + 17'd1;
  assign ms_dec  = ms_r - 18'd1;

  always_comb begin
    ct_done = 1'b0;
    ms_cnt  = ms_r;
    cim_cnt = cim_r;
    if (ms_r == '0) begin
      ct_done = 1'b1;
    end else if (cim_inc >= {1'b0, cpm_r}) begin
      cim_cnt = '0;
      ms_cnt  = ms_dec;
      ct_done = (ms_dec == '0);
    end else begin
      cim_cnt = cim_inc[15:0];
    end
  end

  // entry load for start or end of gap
  assign ld_entry = do_start ? e0_r : (byp_vld_r ? byp_data_r : ram_rdata);
  assign ld_code  = ld_entry[15:8];
  assign ld_len   = ld_entry[7:0];
  assign pos_ld   = do_start ? '0 : pos_inc;
  assign ld_stop  = (pos_ld >= (PW+1)'(SCORE_DEPTH)) || (ld_code == END_MARK);
  assign ld_cur   = (ld_code < NOTE_COUNT) ? ld_code[5:0] : 6'd0;
  assign ms_load  = {10'd0, ld_len} * {8'd0, unit_r};

  // tone counter
  assign tone_inc = tone_r + 16'd1;
  assign tone_rl  = reload_value(cur_r);

  always_comb begin
    phase_nxt = phase_r;
    if (do_load) begin
      phase_nxt = ld_stop ? PH_IDLE : PH_NOTE;
    end else if (is_tick) begin
      unique case (phase_r)
        PH_NOTE: phase_nxt = ct_done ? PH_GAP : PH_NOTE;
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_comb begin
    tone_nxt = tone_r;
    pin_nxt  = pin_r;
    cur_nxt  = cur_r;
    pos_nxt  = pos_r;
    ms_nxt   = ms_r;
    cim_nxt  = cim_r;
    fin      = 1'b0;
    if (do_load) begin
      if (ld_stop) begin
        pin_nxt = 1'b1;
        pos_nxt = '0;
        ms_nxt  = '0;
        cim_nxt = '0;
        fin     = 1'b1;
      end else begin
        cur_nxt = ld_cur;
        pos_nxt = pos_ld[PW-1:0];
        ms_nxt  = ms_load;
        cim_nxt = '0;
      end
    end else if (is_tick && (phase_r == PH_NOTE)) begin
      tone_nxt = tone_inc;
      if ((tone_inc == '0) && (tone_rl != '0)) begin
        tone_nxt = tone_rl;
        pin_nxt  = !pin_r;
      end
      if (ct_done) begin
        ms_nxt  = {10'd0, gap_r};
        cim_nxt = '0;
      end else begin
        ms_nxt  = ms_cnt;
        cim_nxt = cim_cnt;
      end
    end else if (is_tick && (phase_r == PH_GAP)) begin
      ms_nxt  = ms_cnt;
      cim_nxt = cim_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tone_r  <= '0;
      pin_r   <= 1'b1;
      cur_r   <= '0;
      pos_r   <= '0;
      ms_r    <= '0;
      cim_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      tone_r  <= tone_nxt;
      pin_r   <= pin_nxt;
      cur_r   <= cur_nxt;
      pos_r   <= pos_nxt;
      ms_r    <= ms_nxt;
      cim_r   <= cim_nxt;
    end
  end

  // output register
  assign pos_ext = {7'd0, pos_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_level_r   <= pin_nxt;
      out_playing_r <= (phase_nxt != PH_IDLE);
      out_fin_r     <= fin;
      out_pos_r     <= (phase_nxt != PH_IDLE) ? pos_ext[6:0] : 7'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_buzzer_level  = out_level_r;
  assign out_playing       = out_playing_r;
  assign out_finished      = out_fin_r;
  assign out_note_position = out_pos_r;

  `BMP_ASSERT_NOW(a_idle_pin_high, phase_r == PH_IDLE, pin_r, "pin low while idle")
  `BMP_ASSERT_NOW(a_idle_timers_clear, phase_r == PH_IDLE, (ms_r == '0) && (cim_r == '0),
                  "timers not cleared while idle")
  `BMP_ASSERT_NOW(a_note_in_table, phase_r != PH_IDLE, cur_r < NOTE_COUNT[5:0] + 6'd0 ||
                  cur_r == 6'd36, "note index beyond reload table")
  `BMP_ASSERT_NEXT(a_start_no_gap, do_start, phase_r != PH_GAP, "start left player in gap")
  `BMP_ASSERT_NEXT(a_fin_stops, in_acc && fin, out_valid_r && out_fin_r && !out_playing_r,
                   "finished result still playing")

endmodule
`default_nettype wire

// ----- rtl/bmp_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module bmp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- bench/bmp_monitor.sv -----
// Monitor for the buzzer melody player: predicts every pin report and compares it
module bmp_monitor #(
  parameter int unsigned DEPTH = bmp_pkg::SCORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [6:0]  in_entry_index,
  input  logic [7:0]  in_note_code,
  input  logic [7:0]  in_note_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_buzzer_level,
  input  logic        out_playing,
  input  logic        out_finished,
  input  logic [6:0]  out_note_position,
  output int          mismatch_count,
  output int          pending_count,
  output int          report_count,
  output int          stop_count,
  output int          level_change_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import bmp_pkg::*;

  typedef struct packed {
    logic       level;
    logic       playing;
    logic       finished;
    logic [6:0] position;
  } pin_report_t;

  logic [15:0] tone_reload [37] = '{
    16'd0,
    16'd63628, 16'd63731, 16'd63835, 16'd63928, 16'd64021, 16'd64103,
    16'd64185, 16'd64260, 16'd64331, 16'd64400, 16'd64463, 16'd64528,
    16'd64580, 16'd64633, 16'd64684, 16'd64732, 16'd64777, 16'd64820,
    16'd64860, 16'd64898, 16'd64934, 16'd64968, 16'd65000, 16'd65030,
    16'd65058, 16'd65085, 16'd65110, 16'd65134, 16'd65157, 16'd65178,
    16'd65198, 16'd65217, 16'd65235, 16'd65252, 16'd65268, 16'd65283
  };

  logic [7:0]  score_code [DEPTH];
  logic [7:0]  score_len [DEPTH];
  logic [15:0] tone_cnt;
  logic        pin_q;
  logic [5:0]  note_q;
  int unsigned play_pos;
  phase_t      phase_q;
  int unsigned ms_left_q;
  int unsigned ms_cyc_q;
  int unsigned cpm_q;
  int unsigned unit_q;
  int unsigned gap_q;
  logic        last_level;

  pin_report_t awaited_reports [$];

  // returns 1 when play stops at an end mark or past the last entry
  function automatic bit open_entry();
    if (play_pos >= DEPTH || score_code[play_pos] == END_MARK) begin
      phase_q   = PH_IDLE;
      pin_q     = 1'b1;
      play_pos  = 0;
      ms_left_q = 0;
      ms_cyc_q  = 0;
      return 1'b1;
    end
    note_q    = (score_code[play_pos] < NOTE_COUNT) ? score_code[play_pos][5:0] : 6'd0;
    ms_left_q = (score_len[play_pos] * unit_q) & 32'h3FFFF;
    ms_cyc_q  = 0;
    phase_q   = PH_NOTE;
    return 1'b0;
  endfunction

  function automatic bit run_clock();
    if (ms_left_q == 0) return 1'b1;
    ms_cyc_q++;
    if (ms_cyc_q >= cpm_q) begin
      ms_cyc_q = 0;
      ms_left_q--;
      if (ms_left_q == 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit machine_tick();
    logic [15:0] reload;
    if (phase_q == PH_NOTE) begin
      tone_cnt = tone_cnt + 16'd1;
      if (tone_cnt == 16'd0) begin
        reload = tone_reload[note_q];
        if (reload != 16'd0) begin
          tone_cnt = reload;
          pin_q    = ~pin_q;
        end
      end
      if (run_clock()) begin
        phase_q   = PH_GAP;
        ms_left_q = gap_q;
        ms_cyc_q  = 0;
      end
    end else if (phase_q == PH_GAP) begin
      if (run_clock()) begin
        play_pos++;
        return open_entry();
      end
    end
    return 1'b0;
  endfunction

  function automatic pin_report_t predict_report(logic [1:0] kind, logic [6:0] idx,
                                                 logic [7:0] code, logic [7:0] len);
    pin_report_t r;
    bit          stopped;
    stopped = 1'b0;
    case (kind)
      REQ_TICK: begin
        stopped = machine_tick();
      end
      REQ_WRITE: begin
        if (idx < DEPTH) begin
          score_code[idx] = code;
          score_len[idx]  = len;
        end
      end
      REQ_START: begin
        play_pos = 0;
        stopped  = open_entry();
      end
      default: ;
    endcase
    r.level    = pin_q;
    r.playing  = (phase_q != PH_IDLE);
    r.finished = stopped;
    r.position = (phase_q != PH_IDLE) ? play_pos[6:0] : 7'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    pin_report_t want;
    pin_report_t got;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        score_code[i] = 8'd0;
        score_len[i]  = 8'd0;
      end
      tone_cnt           = 16'd0;
      pin_q              = 1'b1;
      note_q             = 6'd0;
      play_pos           = 0;
      phase_q            = PH_IDLE;
      ms_left_q          = 0;
      ms_cyc_q           = 0;
      cpm_q              = 32'(CYCLES_PER_MS_RST);
      unit_q             = 32'(UNIT_MS_RST);
      gap_q              = 32'(GAP_MS_RST);
      last_level         = 1'b1;
      mismatch_count     = 0;
      report_count       = 0;
      stop_count         = 0;
      level_change_count = 0;
      awaited_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CYCLES_PER_MS: cpm_q = 32'(cfg_wdata);
          CFG_UNIT_MS:       unit_q = 32'(cfg_wdata[9:0]);
          CFG_GAP_MS:        gap_q = 32'(cfg_wdata[7:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = predict_report(in_req_type, in_entry_index, in_note_code, in_note_length);
        if (want.level != last_level) level_change_count++;
        last_level = want.level;
        if (want.finished) stop_count++;
        awaited_reports.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {out_buzzer_level, out_playing, out_finished, out_note_position};
        report_count++;
        if (awaited_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] report with no request pending: level %0b playing %0b done %0b pos %0d",
                     $realtime, got.level, got.playing, got.finished, got.position);
        end else begin
          want = awaited_reports.pop_front();
          if (got.level !== want.level || got.playing !== want.playing ||
              got.finished !== want.finished || got.position !== want.position) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] report %0d mismatch (exp/got): level %0b/%0b playing %0b/%0b",
                       $realtime, report_count, want.level, got.level, want.playing,
                       got.playing);
              $display("    done %0b/%0b pos %0d/%0d",
                       want.finished, got.finished, want.position, got.position);
            end
          end
        end
      end
    end
    pending_count = awaited_reports.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: drives requests and register writes into the buzzer melody player
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmp_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int STALL_LIMIT      = 5000;
  localparam int HOLD_CYCLES      = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_CYCLES_PER_MS;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = REQ_TICK;
  logic [6:0]  in_entry_index = 7'd0;
  logic [7:0]  in_note_code = 8'd0;
  logic [7:0]  in_note_length = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_buzzer_level;
  logic        out_playing;
  logic        out_finished;
  logic [6:0]  out_note_position;

  int mismatch_count;
  int pending_count;
  int report_count;
  int stop_count;
  int level_change_count;

  int requests_sent = 0;
  int settings_used = 0;
  int filled = 0;
  int burst_left = 0;
  int holds_asked = 0;

  buzzer_melody_player_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .in_note_code      (in_note_code),
    .in_note_length    (in_note_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_buzzer_level  (out_buzzer_level),
    .out_playing       (out_playing),
    .out_finished      (out_finished),
    .out_note_position (out_note_position)
  );

  bmp_monitor monitor_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_entry_index     (in_entry_index),
    .in_note_code       (in_note_code),
    .in_note_length     (in_note_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_buzzer_level   (out_buzzer_level),
    .out_playing        (out_playing),
    .out_finished       (out_finished),
    .out_note_position  (out_note_position),
    .mismatch_count     (mismatch_count),
    .pending_count      (pending_count),
    .report_count       (report_count),
    .stop_count         (stop_count),
    .level_change_count (level_change_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic offer(logic [1:0] kind, logic [6:0] idx, logic [7:0] code, logic [7:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_entry_index <= idx;
    in_note_code   <= code;
    in_note_length <= len;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) offer(REQ_TICK, 7'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic store(logic [6:0] idx, logic [7:0] code, logic [7:0] len);
    offer(REQ_WRITE, idx, code, len);
    if (int'(idx) >= filled) filled = int'(idx) + 1;
  endtask

  task automatic begin_play();
    offer(REQ_START, 7'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_registers(logic [15:0] cpm, logic [9:0] unit, logic [7:0] gap);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CYCLES_PER_MS;
    cfg_wdata <= cpm;
    @(negedge clk);
    cfg_index <= CFG_UNIT_MS;
    cfg_wdata <= {6'($urandom), unit};
    @(negedge clk);
    cfg_index <= CFG_GAP_MS;
    cfg_wdata <= {8'($urandom), gap};
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'($urandom_range(1, 36));
    if (r < 75) return 8'd0;
    if (r < 87) return 8'($urandom_range(37, 254));
    if (r < 94) return END_MARK;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(0, 4));
    if (r < 90) return 8'($urandom_range(0, 32));
    return 8'($urandom);
  endfunction

  function automatic int tick_run();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 6);
    return $urandom_range(7, 24);
  endfunction

  // the last written entry stays an end mark until the whole store is written,
  // so play never reaches an entry that was never written
  task automatic random_request();
    int unsigned r;
    logic [6:0]  idx;
    logic [7:0]  code;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_ticks(tick_run());
    end else if (r < 80) begin
      if (filled < 128 && $urandom_range(0, 2) == 0) begin
        idx  = 7'(filled);
        code = END_MARK;
      end else begin
        idx  = 7'($urandom_range(0, filled - 1));
        code = (filled < 128 && int'(idx) == filled - 1) ? END_MARK : pick_code();
      end
      store(idx, code, pick_len());
    end else if (r < 91) begin
      begin_play();
    end else begin
      offer(REQ_NONE, 7'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // receiver: changing ready patterns, plus long hold-offs to back up the input
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned clock_no;
    int unsigned hold_left;
    int          holds_seen;
    clock_no   = 0;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        clock_no++;
        if (holds_seen != holds_asked) begin
          holds_seen = holds_asked;
          hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= clock_no[3];
          endcase
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no request or report moved for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [7:0] code;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    set_registers(16'd1, 10'd1, 8'd0);
    offer(REQ_TICK, 7'h7F, 8'hFF, 8'hFF);
    offer(REQ_NONE, 7'h7F, 8'hFF, 8'hFF);
    offer(REQ_NONE, 7'h00, 8'h00, 8'h00);
    store(7'd0, END_MARK, 8'hFF);
    begin_play();
    store(7'd0, 8'd1, 8'd0);
    store(7'd1, 8'd0, 8'd2);
    store(7'd2, 8'd37, 8'd1);
    store(7'd3, 8'd254, 8'd0);
    store(7'd4, 8'd36, 8'd3);
    store(7'd5, END_MARK, 8'd0);
    begin_play();
    send_ticks(4);
    store(7'd6, END_MARK, 8'd0);
    store(7'd5, 8'd12, 8'd1);
    send_ticks(3);
    begin_play();
    // receiver holds off while ticks keep coming
    holds_asked++;
    send_ticks(30);

    // widest register values on a long note
    set_registers(16'hFFFF, 10'd1023, 8'd255);
    store(7'd0, 8'd36, 8'd255);
    begin_play();
    send_ticks(40);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_registers(16'd1, 10'd1, 8'd0);
        1: set_registers(16'd0, 10'd2, 8'd1);
        2: set_registers(16'd3, 10'd1, 8'd4);
        3: set_registers(16'd1, 10'd1023, 8'd255);
        default: set_registers(16'($urandom_range(0, 4)), 10'($urandom_range(1, 3)),
                               8'($urandom_range(0, 3)));
      endcase
      repeat (12) random_request();
    end

    // whole store without an end mark: play runs off the last entry
    set_registers(16'd0, 10'd1, 8'd0);
    for (int i = 0; i < 128; i++) begin
      code = pick_code();
      if (code == END_MARK) code = 8'd20;
      store(7'(i), code, 8'($urandom_range(0, 1)));
    end
    begin_play();
    send_ticks(270);

    drain();
    repeat (5) @(negedge clk);

    $display("Run covered %0d requests over %0d register settings and %0d reports,",
             requests_sent, settings_used, report_count);
    $display("with %0d expected pin level changes and %0d plays stopped.",
             level_change_count, stop_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d reports still awaited", mismatch_count, pending_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bmp_pkg.sv
rtl/bmp_ram.sv
rtl/buzzer_melody_player_unit.sv
bench/bmp_monitor.sv
bench/tb_top.sv
